// ----- hw/rtl/csa_pkg.sv -----
// Shared constants, types and constant functions for the char surface area pipeline.
package csa_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_MODEL = 3'd0;
	localparam logic [2:0] REG_AREA  = 3'd1;
	localparam logic [2:0] REG_INV   = 3'd2;
	localparam logic [2:0] REG_PSI   = 3'd3;
	localparam logic [2:0] REG_EXP   = 3'd4;
	localparam logic [2:0] REG_THR   = 3'd5;

	// Model codes
	localparam logic [1:0] MODEL_PORE = 2'd0;
	localparam logic [1:0] MODEL_VOL  = 2'd1;
	localparam logic [1:0] MODEL_CORE = 2'd2;

	// ln 2 in Q0.30
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	// floor(v/3) == (v * DIV3_RECIP) >> 33 for any 32-bit v
	localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

	// Stage counts
	localparam int LOG_STEPS  = 24;
	localparam int SQRT_STEPS = 32;

	// Per-item side data carried along the pipeline
	typedef struct packed {
		logic        region;
		logic        xnz;
		logic [31:0] area1;
		logic        sat1;
	} side_t;

	// Integer square root, bit by bit (elaboration only)
	function automatic logic [63:0] csa_isqrt(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] b;
		rem = v;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-idx) in Q1.30 from the truncated square root chain
	function automatic logic [31:0] csa_exp_factor(input int idx);
		logic [63:0] t;
		t = 64'd1 << 31;
		for (int i = 1; i <= idx; i++) begin
			t = csa_isqrt(t << 30);
		end
		return t[31:0];
	endfunction

endpackage

// ----- hw/rtl/char_surface_area_model.sv -----
// Char specific surface area pipeline: random pore, volumetric and shrinking core models.
// Throughput: one item per cycle while the output is not stalled; the depth comes from the
// 24-step log2 squaring chain and the 32-step square root, each step one register stage.
// A stalled output stops the pipeline only when its last stage holds an item.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the register defaults.
module char_surface_area_model (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] coke_fraction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] surface_area,
	output logic        in_region,
	output logic        invalid,
	output logic        saturated,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import csa_pkg::*;

	localparam int NST = 68;

	// Configuration registers
	logic [1:0]  model_q;
	logic [31:0] s0_q;
	logic [23:0] inv_q;
	logic [23:0] psi_q;
	logic [15:0] n_q;
	logic [15:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= MODEL_PORE;
			s0_q    <= 32'd256;
			inv_q   <= 24'd65536;
			psi_q   <= 24'd65536;
			n_q     <= 16'd4096;
			thr_q   <= 16'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODEL: model_q <= cfg_data[1:0];
				REG_AREA:  s0_q    <= cfg_data;
				REG_INV:   inv_q   <= cfg_data[23:0];
				REG_PSI:   psi_q   <= cfg_data[23:0];
				REG_EXP:   n_q     <= cfg_data[15:0];
				REG_THR:   thr_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Flow control
	logic            out_valid_q;
	logic [NST:1]    vld_s;
	logic            out_load;
	logic            adv;

	assign out_load = !out_valid_q || out_ready;
	assign adv      = out_load || !vld_s[NST];
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) vld_s <= {vld_s[NST-1:1], in_valid};
			if (out_load) out_valid_q <= vld_s[NST];
		end
	end

	// Stage 1: residual x = f * 1/f0 (Q8.32), region test
	logic [39:0] x_s1;
	logic        reg_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= 40'(coke_fraction) * 40'(inv_q);
			reg_s1 <= coke_fraction > thr_q;
		end
	end

	// Stage 2: leading one of x, volumetric partial products
	logic [5:0]  lead;
	logic [39:0] x_s2;
	logic [5:0]  p_s2;
	logic [51:0] hi_s2;
	logic [51:0] lo_s2;
	logic        reg_s2;
	logic        xnz_s2;

	always_comb begin
		lead = 6'd0;
		for (int i = 0; i < 40; i++) begin
			if (x_s1[i]) lead = 6'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2   <= x_s1;
			p_s2   <= lead;
			hi_s2  <= 52'(s0_q) * 52'(x_s1[39:20]);
			lo_s2  <= 52'(s0_q) * 52'(x_s1[19:0]);
			reg_s2 <= reg_s1;
			xnz_s2 <= x_s1 != 40'd0;
		end
	end

	// Stage 3: normalize mantissa to Q1.30, finish volumetric area
	logic [69:0] norm_w;
	logic [52:0] vol_sum;
	logic [40:0] vol_q;

	assign norm_w  = {x_s2, 30'd0} >> p_s2;
	assign vol_sum = 53'(hi_s2) + 53'(lo_s2 >> 20);
	assign vol_q   = vol_sum[52:12];

	logic [30:0] lm_s [0:LOG_STEPS];
	logic [23:0] lf_s [0:LOG_STEPS];
	logic [5:0]  lp_s [0:LOG_STEPS];
	side_t       ls_s [0:LOG_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			lm_s[0]        <= norm_w[30:0];
			lf_s[0]        <= 24'd0;
			lp_s[0]        <= p_s2;
			ls_s[0].region <= reg_s2;
			ls_s[0].xnz    <= xnz_s2;
			ls_s[0].sat1   <= |vol_q[40:32];
			ls_s[0].area1  <= (|vol_q[40:32]) ? 32'hFFFF_FFFF : vol_q[31:0];
		end
	end

	// Stages 4..27: log2 fraction bits by repeated squaring
	for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
		logic [61:0] sq;
		assign sq = 62'(lm_s[j]) * 62'(lm_s[j]);
		always_ff @(posedge clk) begin
			if (adv) begin
				if (sq[61]) begin
					lm_s[j+1] <= sq[61:31];
					lf_s[j+1] <= {lf_s[j][22:0], 1'b1};
				end else begin
					lm_s[j+1] <= sq[60:30];
					lf_s[j+1] <= {lf_s[j][22:0], 1'b0};
				end
				lp_s[j+1] <= lp_s[j];
				ls_s[j+1] <= ls_s[j];
			end
		end
	end

	// Stage 28: sign and magnitude of log2 x (Q.24)
	logic        neg_n;
	logic [29:0] mag_n;
	logic        neg_s28;
	logic [29:0] mag_s28;
	side_t       sd_s28;

	assign neg_n = lp_s[LOG_STEPS] < 6'd32;
	assign mag_n = neg_n ? ({6'd32 - lp_s[LOG_STEPS], 24'd0} - {6'd0, lf_s[LOG_STEPS]})
	                     : ({lp_s[LOG_STEPS] - 6'd32, 24'd0} + {6'd0, lf_s[LOG_STEPS]});

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s28 <= neg_n;
			mag_s28 <= mag_n;
			sd_s28  <= ls_s[LOG_STEPS];
		end
	end

	// Stage 29: ln scaling, exponent products
	logic [59:0] lnp_s29;
	logic [45:0] ynp_s29;
	logic [62:0] y3p_s29;
	logic        neg_s29;
	side_t       sd_s29;

	always_ff @(posedge clk) begin
		if (adv) begin
			lnp_s29 <= 60'(mag_s28) * 60'(LN2_Q30);
			ynp_s29 <= 46'(mag_s28) * 46'(n_q);
			y3p_s29 <= 63'({mag_s28, 1'b0}) * 63'(DIV3_RECIP);
			neg_s29 <= neg_s28;
			sd_s29  <= sd_s28;
		end
	end

	// Stage 30: ln|x| and exponent magnitude
	logic [29:0] lnmag_s30;
	logic [33:0] ymag_s30;
	logic        neg_s30;
	side_t       sd_s30;

	always_ff @(posedge clk) begin
		if (adv) begin
			lnmag_s30 <= lnp_s29[59:30];
			ymag_s30  <= (model_q == MODEL_PORE) ? ynp_s29[45:12] : 34'(y3p_s29[62:33]);
			neg_s30   <= neg_s29;
			sd_s30    <= sd_s29;
		end
	end

	// Stage 31: psi * ln x
	logic [53:0] plp;
	logic [37:0] pl_s31;
	logic [33:0] ymag_s31;
	logic        neg_s31;
	side_t       sd_s31;

	assign plp = 54'(psi_q) * 54'(lnmag_s30);

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s31   <= plp[53:16];
			ymag_s31 <= ymag_s30;
			neg_s31  <= neg_s30;
			sd_s31   <= sd_s30;
		end
	end

	// Stage 32: root argument, integer and fraction parts of the exponent
	localparam logic [38:0] ONE_Q24 = 39'd1 << 24;

	logic [38:0]        s_n;
	logic               inv_n;
	logic [9:0]         ip_n;
	logic [23:0]        fp_n;
	logic signed [11:0] k_n;
	logic [23:0]        frac_n;

	assign ip_n = ymag_s31[33:24];
	assign fp_n = ymag_s31[23:0];

	always_comb begin
		inv_n = 1'b0;
		if (neg_s31) begin
			s_n = ONE_Q24 + 39'(pl_s31);
		end else if (39'(pl_s31) > ONE_Q24) begin
			s_n   = 39'd0;
			inv_n = model_q == MODEL_PORE;
		end else begin
			s_n = ONE_Q24 - 39'(pl_s31);
		end
		if (neg_s31 && fp_n != 24'd0) begin
			k_n    = -$signed(12'(ip_n)) - 12'sd1;
			frac_n = 24'(ONE_Q24 - 39'(fp_n));
		end else if (neg_s31) begin
			k_n    = -$signed(12'(ip_n));
			frac_n = 24'd0;
		end else begin
			k_n    = $signed(12'(ip_n));
			frac_n = fp_n;
		end
	end

	logic [63:0]        rv_s [0:SQRT_STEPS];
	logic [63:0]        rr_s [0:SQRT_STEPS];
	logic [31:0]        em_s [0:SQRT_STEPS];
	logic [23:0]        ef_s [0:SQRT_STEPS];
	logic signed [11:0] sh_s [0:SQRT_STEPS];
	logic               iv_s [0:SQRT_STEPS];
	side_t              rs_s [0:SQRT_STEPS];

	always_ff @(posedge clk) begin
		if (adv) begin
			rv_s[0] <= {1'b0, s_n, 24'd0};
			rr_s[0] <= 64'd0;
			em_s[0] <= 32'd1 << 30;
			ef_s[0] <= frac_n;
			sh_s[0] <= k_n - 12'sd24;
			iv_s[0] <= inv_n;
			rs_s[0] <= sd_s31;
		end
	end

	// Stages 33..64: square root one bit a stage, 2^frac one factor a stage over the first LOG_STEPS stages
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0] trial;
		logic [31:0] em_n;
		assign trial = rr_s[j] + BIT;

		if (j < LOG_STEPS) begin : g_exp
			localparam logic [31:0] FACT = csa_exp_factor(j + 1);
			logic [63:0] ep;
			assign ep   = 64'(em_s[j]) * 64'(FACT);
			assign em_n = ef_s[j][LOG_STEPS-1-j] ? ep[61:30] : em_s[j];
		end else begin : g_hold
			assign em_n = em_s[j];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rv_s[j] >= trial) begin
					rv_s[j+1] <= rv_s[j] - trial;
					rr_s[j+1] <= (rr_s[j] >> 1) + BIT;
				end else begin
					rv_s[j+1] <= rv_s[j];
					rr_s[j+1] <= rr_s[j] >> 1;
				end
				em_s[j+1] <= em_n;
				ef_s[j+1] <= ef_s[j];
				sh_s[j+1] <= sh_s[j];
				iv_s[j+1] <= iv_s[j];
				rs_s[j+1] <= rs_s[j];
			end
		end
	end

	// Stage 65: t = S0 * 2^frac, pick root term
	logic [63:0]        tp;
	logic [33:0]        t_s65;
	logic [31:0]        root_s65;
	logic signed [11:0] sh_s65;
	logic               iv_s65;
	side_t              sd_s65;

	assign tp = 64'(s0_q) * 64'(em_s[SQRT_STEPS]);

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s65    <= tp[63:30];
			root_s65 <= (model_q == MODEL_PORE) ? rr_s[SQRT_STEPS][31:0] : 32'(ONE_Q24);
			sh_s65   <= sh_s[SQRT_STEPS];
			iv_s65   <= iv_s[SQRT_STEPS];
			sd_s65   <= rs_s[SQRT_STEPS];
		end
	end

	// Stage 66: t * root as two partial products
	logic [49:0]        plo_s66;
	logic [49:0]        phi_s66;
	logic signed [11:0] sh_s66;
	logic               iv_s66;
	side_t              sd_s66;

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s66 <= 50'(t_s65) * 50'(root_s65[15:0]);
			phi_s66 <= 50'(t_s65) * 50'(root_s65[31:16]);
			sh_s66  <= sh_s65;
			iv_s66  <= iv_s65;
			sd_s66  <= sd_s65;
		end
	end

	// Stage 67: sum partial products, wraps at 64 bits
	logic [65:0]        usum;
	logic [63:0]        u_s67;
	logic signed [11:0] sh_s67;
	logic               iv_s67;
	side_t              sd_s67;

	assign usum = {phi_s66, 16'd0} + 66'(plo_s66);

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s67  <= usum[63:0];
			sh_s67 <= sh_s66;
			iv_s67 <= iv_s66;
			sd_s67 <= sd_s66;
		end
	end

	// Stage 68: scale by 2^sh with saturation, select model result
	logic [11:0] nsh;
	logic [95:0] wup;
	logic [63:0] wdn;
	logic [31:0] sc_area;
	logic        sc_sat;
	logic [31:0] fin_area;
	logic        fin_inv;
	logic        fin_sat;

	assign nsh = 12'(-sh_s67);
	assign wup = {32'd0, u_s67} << sh_s67[4:0];
	assign wdn = u_s67 >> nsh[5:0];

	always_comb begin
		sc_area = 32'd0;
		sc_sat  = 1'b0;
		if (u_s67 != 64'd0) begin
			if (!sh_s67[11]) begin
				if ((|sh_s67[10:5]) || (|wup[95:32])) begin
					sc_area = 32'hFFFF_FFFF;
					sc_sat  = 1'b1;
				end else begin
					sc_area = wup[31:0];
				end
			end else if (!(|nsh[11:6])) begin
				if (|wdn[63:32]) begin
					sc_area = 32'hFFFF_FFFF;
					sc_sat  = 1'b1;
				end else begin
					sc_area = wdn[31:0];
				end
			end
		end
	end

	always_comb begin
		fin_area = 32'd0;
		fin_inv  = 1'b0;
		fin_sat  = 1'b0;
		if (sd_s67.region && sd_s67.xnz) begin
			case (model_q) inside
				MODEL_VOL: begin
					fin_area = sd_s67.area1;
					fin_sat  = sd_s67.sat1;
				end
				MODEL_PORE, MODEL_CORE: begin
					if (iv_s67) begin
						fin_inv = 1'b1;
					end else begin
						fin_area = sc_area;
						fin_sat  = sc_sat;
					end
				end
				default: ;
			endcase
		end
	end

	logic [31:0] area_s68;
	logic        reg_s68;
	logic        inv_s68;
	logic        sat_s68;

	always_ff @(posedge clk) begin
		if (adv) begin
			area_s68 <= fin_area;
			reg_s68  <= sd_s67.region;
			inv_s68  <= fin_inv;
			sat_s68  <= fin_sat;
		end
	end

	// Output register
	logic [31:0] area_q;
	logic        region_q;
	logic        inv_q2;
	logic        sat_q;

	always_ff @(posedge clk) begin
		if (out_load && vld_s[NST]) begin
			area_q   <= area_s68;
			region_q <= reg_s68;
			inv_q2   <= inv_s68;
			sat_q    <= sat_s68;
		end
	end

	assign out_valid    = out_valid_q;
	assign surface_area = area_q;
	assign in_region    = region_q;
	assign invalid      = inv_q2;
	assign saturated    = sat_q;

endmodule

// ----- tb/char_surface_area_model_tb.sv -----
// Self-checking testbench for the char specific surface area pipeline.
`timescale 1ns / 1ps

module char_surface_area_model_tb;
	import csa_pkg::*;

	localparam int DRAIN_CYCLES = 100;
	localparam logic [63:0] ONE_Q24 = 64'd1 << 24;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] LN2 = 64'd744261118;

	typedef struct packed {
		logic [31:0] area;
		logic        region;
		logic        invalid;
		logic        sat;
	} area_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] coke_fraction;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] surface_area;
	logic        in_region;
	logic        invalid;
	logic        saturated;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	char_surface_area_model dut (.*);

	// predictor copy of the configuration
	logic [1:0]  cur_model;
	logic [31:0] cur_s0;
	logic [23:0] cur_inv;
	logic [23:0] cur_psi;
	logic [15:0] cur_exp;
	logic [15:0] cur_thr;

	logic [15:0]  fraction_queue[$];
	area_result_t expected_areas[$];
	int           mismatch_count;
	int           idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 of a nonzero Q8.32 value, Q.24
	function automatic longint log2_fixed(input logic [63:0] x);
		int          p;
		logic [63:0] m;
		longint      fr;
		p = 63;
		fr = 0;
		while (p > 0 && x[p] == 1'b0) p--;
		m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			fr = fr << 1;
			if (m >= 2 * ONE_Q30) begin
				m = m >> 1;
				fr = fr | 1;
			end
		end
		return longint'(p - 32) * longint'(ONE_Q24) + fr;
	endfunction

	function automatic logic [63:0] pow2_fraction(input logic [63:0] fr);
		logic [63:0] m;
		logic [63:0] t;
		m = ONE_Q30;
		t = 2 * ONE_Q30;
		for (int i = 1; i <= 24; i++) begin
			t = int_sqrt(t << 30);
			if (fr[24 - i]) m = (m * t) >> 30;
		end
		return m;
	endfunction

	function automatic area_result_t predict_area(input logic [15:0] f);
		area_result_t res;
		logic [63:0]  x, s0, mag, ymag, root, ip, fp, fr, m, t, u, lnmag, pl, s, hi, lo, v;
		longint       lg, k, sh;
		logic         neg;
		res = '0;
		res.region = f > cur_thr;
		x = 64'(f) * 64'(cur_inv);
		s0 = 64'(cur_s0);
		if (res.region && x != 0 && cur_model == MODEL_VOL) begin
			hi = s0 * (x >> 20);
			lo = s0 * (x & 64'hFFFFF);
			v = (hi + (lo >> 20)) >> 12;
			if (v > 64'hFFFFFFFF) begin
				res.sat = 1'b1;
				res.area = '1;
			end else begin
				res.area = v[31:0];
			end
		end else if (res.region && x != 0 && (cur_model == MODEL_PORE || cur_model == MODEL_CORE)) begin
			lg = log2_fixed(x);
			neg = lg < 0;
			mag = neg ? 64'(-lg) : 64'(lg);
			root = ONE_Q24;
			if (cur_model == MODEL_PORE) begin
				lnmag = (mag * LN2) >> 30;
				pl = (64'(cur_psi) * lnmag) >> 16;
				ymag = (mag * 64'(cur_exp)) >> 12;
				s = 0;
				if (neg) s = ONE_Q24 + pl;
				else if (pl > ONE_Q24) res.invalid = 1'b1;
				else s = ONE_Q24 - pl;
				root = int_sqrt(s << 24);
			end else begin
				ymag = (mag * 2) / 3;
			end
			if (!res.invalid) begin
				ip = ymag >> 24;
				fp = ymag & (ONE_Q24 - 1);
				if (neg && fp != 0) begin
					k = -longint'(ip) - 1;
					fr = ONE_Q24 - fp;
				end else if (neg) begin
					k = -longint'(ip);
					fr = 0;
				end else begin
					k = longint'(ip);
					fr = fp;
				end
				m = pow2_fraction(fr);
				t = (s0 * m) >> 30;
				u = t * root;
				sh = k - 24;
				// scale by 2^sh with saturation
				if (u == 0) begin
					res.area = 0;
				end else if (sh >= 0) begin
					if (sh >= 32 || u > (64'hFFFFFFFF >> sh)) begin
						res.sat = 1'b1;
						res.area = '1;
					end else begin
						res.area = 32'(u << sh);
					end
				end else if (-sh < 64) begin
					v = u >> (-sh);
					if (v > 64'hFFFFFFFF) begin
						res.sat = 1'b1;
						res.area = '1;
					end else begin
						res.area = v[31:0];
					end
				end
			end
		end
		return res;
	endfunction

	// driver: one transfer per handshake, random idle cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			coke_fraction <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) expected_areas.push_back(predict_area(coke_fraction));
			if (fraction_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				coke_fraction <= fraction_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and output stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= idle_pct;
			if (out_valid && out_ready) begin
				if (expected_areas.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result area=%h", surface_area);
				end else begin
					area_result_t e;
					e = expected_areas.pop_front();
					if (e.area !== surface_area || e.region !== in_region ||
						e.invalid !== invalid || e.sat !== saturated) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("area mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
								e.area, e.region, e.invalid, e.sat,
								surface_area, in_region, invalid, saturated);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_MODEL: cur_model = val[1:0];
			REG_AREA:  cur_s0 = val;
			REG_INV:   cur_inv = val[23:0];
			REG_PSI:   cur_psi = val[23:0];
			REG_EXP:   cur_exp = val[15:0];
			REG_THR:   cur_thr = val[15:0];
			default: ;
		endcase
	endtask

	// wait until queue empties and all results arrive, then let the pipe settle
	task automatic drain_all();
		while (fraction_queue.size() != 0 || in_valid || expected_areas.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [1:0] mdl, input logic [31:0] s0, input logic [23:0] inv,
		input logic [23:0] psi, input logic [15:0] ex, input logic [15:0] thr, input int n);
		write_reg(REG_MODEL, 32'(mdl));
		write_reg(REG_AREA, s0);
		write_reg(REG_INV, 32'(inv));
		write_reg(REG_PSI, 32'(psi));
		write_reg(REG_EXP, 32'(ex));
		write_reg(REG_THR, 32'(thr));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(5))
				0: fraction_queue.push_back(16'($urandom_range(15)));
				1: fraction_queue.push_back(16'hFFFF - 16'($urandom_range(15)));
				default: fraction_queue.push_back(16'($urandom));
			endcase
		end
		drain_all();
	endtask

	initial begin
		mismatch_count = 0;
		idle_pct = 12;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_model = MODEL_PORE;
		cur_s0 = 32'd256;
		cur_inv = 24'd65536;
		cur_psi = 24'd65536;
		cur_exp = 16'd4096;
		cur_thr = 16'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: reset settings, field extremes
		fraction_queue.push_back(16'h0000);
		fraction_queue.push_back(16'h0001);
		fraction_queue.push_back(16'h8000);
		fraction_queue.push_back(16'hFFFF);
		fraction_queue.push_back(16'h5555);
		fraction_queue.push_back(16'hAAAA);
		drain_all();
		// invalid root: large psi with x > 1
		run_phase(MODEL_PORE, 32'h0001_0000, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'd0, 6);
		// zero residual and reserved code
		run_phase(MODEL_PORE, 32'd256, 24'd0, 24'd65536, 16'd4096, 16'd0, 4);
		run_phase(2'd3, 32'hFFFF_FFFF, 24'd65536, 24'd0, 16'd0, 16'h8000, 5);
		// overflow settings for the volumetric model (threshold keeps all out of region) and the shrinking core model
		run_phase(MODEL_VOL, 32'hFFFF_FFFF, 24'hFFFFFF, 24'd0, 16'd0, 16'hFFFF, 3);
		run_phase(MODEL_CORE, 32'hFFFF_FFFF, 24'hFFFFFF, 24'd0, 16'd0, 16'd0, 3);
		// back-to-back run with no idle cycles and no output stalls
		idle_pct = 0;
		run_phase(MODEL_PORE, 32'hFFFF_FFFF, 24'hFFFFFF, 24'd0, 16'hFFFF, 16'd0, 40);
		idle_pct = 12;
		// random phases
		for (int p = 0; p < 16; p++)
			run_phase(2'($urandom_range(3)), $urandom, 24'($urandom), 24'($urandom_range(1) ?
				$urandom_range(131072) : $urandom), 16'($urandom),
				16'($urandom_range(1) ? 0 : $urandom), 48);
		if (mismatch_count == 0 && expected_areas.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hard limit
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
